FILE: src/lobm_pkg.sv
// Package for the limit order book matcher: request kinds, status codes,
// sequencer states and field widths. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lobm_pkg;
   localparam int IdWidth    = 32;
   localparam int PriceWidth = 16;
   localparam int QtyWidth   = 24;
   localparam int SeqWidth   = 32;
   localparam int MaxFills   = 32;
   localparam int FillCntWidth = 6;

   typedef enum logic [1:0] {
      KIND_ADD    = 2'd0,
      KIND_CANCEL = 2'd1,
      KIND_MODIFY = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_QTY   = 3'd1,
      ST_BAD_PRICE = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_BOOK_FULL = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_FILL,
      S_EMIT,
      S_DONE
   } state_type;
endpackage
`default_nettype wire

FILE: src/lobm_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on lobm_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface lobm_req_if;
   import lobm_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [1:0]            kind;
   logic [IdWidth-1:0]    order_id;
   logic                  is_buy;
   logic [PriceWidth-1:0] limit_price;
   logic [QtyWidth-1:0]   quantity;
   modport source (output valid, kind, order_id, is_buy, limit_price, quantity,
                   input ready);
   modport sink   (input valid, kind, order_id, is_buy, limit_price, quantity,
                   output ready);
endinterface

interface lobm_rsp_if;
   import lobm_pkg::*;
   logic                  valid;
   logic                  ready;
   logic                  is_trade;
   logic [IdWidth-1:0]    buyer_id;
   logic [IdWidth-1:0]    seller_id;
   logic [PriceWidth-1:0] fill_price;
   logic [QtyWidth-1:0]   fill_quantity;
   logic [SeqWidth-1:0]   fill_sequence;
   logic [2:0]            status;
   logic [QtyWidth-1:0]   left_over;
   logic                  last;
   modport source (output valid, is_trade, buyer_id, seller_id, fill_price,
                   fill_quantity, fill_sequence, status, left_over, last,
                   input ready);
   modport sink   (input valid, is_trade, buyer_id, seller_id, fill_price,
                   fill_quantity, fill_sequence, status, left_over, last,
                   output ready);
endinterface
`default_nettype wire

FILE: src/limit_order_book_matcher.sv
// Price-time priority limit order book, top level and sequencer.
// Depends on lobm_pkg and the channel interfaces in lobm_if.sv.
`timescale 1ns / 1ps
`default_nettype none
// The book holds BOOK_DEPTH resting orders in flip-flops. One shared compare
// unit walks the slots one per cycle, so every search (best counter order,
// id lookup, or free slot) visits every slot. A cancel or modify needs one
// scan; an add scans once more after each fill. Every result waits while the
// response side stalls. One request is in flight at a time; the response
// register holds each result until it is taken.
module limit_order_book_matcher #(
   parameter int BOOK_DEPTH = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   lobm_req_if.sink   req,
   lobm_rsp_if.source rsp
);
   import lobm_pkg::*;

   localparam int IdxW = (BOOK_DEPTH <= 2) ? 1 : $clog2(BOOK_DEPTH);

   // Book storage.
   logic [BOOK_DEPTH-1:0]   slot_valid_ff;
   logic [IdWidth-1:0]      slot_id_ff    [BOOK_DEPTH];
   logic                    slot_buy_ff   [BOOK_DEPTH];
   logic [PriceWidth-1:0]   slot_price_ff [BOOK_DEPTH];
   logic [QtyWidth-1:0]     slot_qty_ff   [BOOK_DEPTH];
   logic [SeqWidth-1:0]     slot_arr_ff   [BOOK_DEPTH];
   logic [SeqWidth-1:0]     arrival_ff;
   logic [SeqWidth-1:0]     trade_ff;

   // Latched request.
   logic [1:0]              kind_ff;
   logic [IdWidth-1:0]      id_ff;
   logic                    buy_ff;
   logic [PriceWidth-1:0]   limit_ff;
   logic [QtyWidth-1:0]     qty_ff;   // remaining quantity for an add
   logic [FillCntWidth:0]   fills_ff;

   // Scan unit.
   state_type               state_ff, state_in;
   logic [IdxW-1:0]         idx_ff;
   logic                    found_ff;
   logic [IdxW-1:0]         best_ff;
   logic                    free_ok_ff;
   logic [IdxW-1:0]         free_ff;

   // Response register.
   logic                    rsp_valid_ff;
   logic                    rsp_trade_ff;
   logic [IdWidth-1:0]      rsp_buyer_ff, rsp_seller_ff;
   logic [PriceWidth-1:0]   rsp_price_ff;
   logic [QtyWidth-1:0]     rsp_fqty_ff;
   logic [SeqWidth-1:0]     rsp_seq_ff;
   logic [2:0]              rsp_status_ff;
   logic [QtyWidth-1:0]     rsp_left_ff;
   logic                    rsp_last_ff;

   logic req_fire, rsp_free, rsp_load, do_trade, scan_end, cand, better;
   logic [PriceWidth-1:0] p, bp;
   logic [SeqWidth-1:0] age, bage;
   logic [QtyWidth-1:0] fill;

   assign req.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign req_fire  = req.valid && req.ready;
   assign rsp_free  = !rsp_valid_ff || rsp.ready;
   assign rsp_load  = rsp_free && (state_ff == S_FILL || state_ff == S_DONE);
   assign scan_end  = (idx_ff == IdxW'(BOOK_DEPTH - 1));

   // Another trade is due while an add still has quantity, a counter order and fewer than MaxFills fills.
   assign do_trade  = (kind_ff == KIND_ADD) && found_ff && (qty_ff != '0) &&
                      (fills_ff != (FillCntWidth+1)'(MaxFills));

   // Shared compare unit: judges the slot under the scan pointer.
   always_comb begin
      p    = slot_price_ff[idx_ff];
      bp   = slot_price_ff[best_ff];
      age  = arrival_ff - slot_arr_ff[idx_ff];
      bage = arrival_ff - slot_arr_ff[best_ff];
      cand = 1'b0;
      better = 1'b0;
      if (kind_ff == KIND_ADD) begin
         cand = slot_valid_ff[idx_ff] && (slot_buy_ff[idx_ff] != buy_ff) &&
                (buy_ff ? (p <= limit_ff) : (p >= limit_ff));
         better = !found_ff || (buy_ff ? (p < bp) : (p > bp)) ||
                  ((p == bp) && (age > bage));
      end else begin
         cand   = slot_valid_ff[idx_ff] && (slot_id_ff[idx_ff] == id_ff);
         better = !found_ff;
      end
      fill = (qty_ff < slot_qty_ff[best_ff]) ? qty_ff : slot_qty_ff[best_ff];
   end

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_fire) begin
            if (req.kind == KIND_ADD && req.quantity != '0 && req.limit_price != '0)
               state_in = S_SCAN;
            else if (req.kind == KIND_CANCEL || req.kind == KIND_MODIFY)
               state_in = S_SCAN;
            else
               state_in = S_DONE;
         end
         S_SCAN: if (scan_end) state_in = S_FILL;
         S_FILL: if (rsp_free) state_in = do_trade ? S_EMIT : S_IDLE;
         S_EMIT: state_in = S_SCAN;
         S_DONE: if (rsp_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath and book updates.
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
         arrival_ff    <= '0;
         trade_ff      <= '0;
         fills_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp.ready && !rsp_load) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (req_fire) begin
               kind_ff  <= req.kind;
               id_ff    <= req.order_id;
               buy_ff   <= req.is_buy;
               limit_ff <= req.limit_price;
               qty_ff   <= req.quantity;
               fills_ff <= '0;
               idx_ff   <= '0;
               found_ff <= 1'b0;
               best_ff  <= '0;
               free_ok_ff <= 1'b0;
               free_ff  <= '0;
               rsp_left_ff   <= '0;
               if (req.kind == KIND_ADD && req.quantity == '0)
                  rsp_status_ff <= ST_BAD_QTY;
               else if (req.kind == KIND_ADD && req.limit_price == '0)
                  rsp_status_ff <= ST_BAD_PRICE;
               else
                  rsp_status_ff <= ST_OK;
            end
            S_SCAN: begin
               if (cand && better) begin
                  found_ff <= 1'b1;
                  best_ff  <= idx_ff;
               end
               if (!slot_valid_ff[idx_ff] && !free_ok_ff) begin
                  free_ok_ff <= 1'b1;
                  free_ff    <= idx_ff;
               end
               idx_ff <= scan_end ? '0 : idx_ff + IdxW'(1);
            end
            S_FILL: if (rsp_free) begin
               if (do_trade) begin
                  // One trade against the best counter order.
                  rsp_valid_ff  <= 1'b1;
                  rsp_trade_ff  <= 1'b1;
                  rsp_buyer_ff  <= buy_ff ? id_ff : slot_id_ff[best_ff];
                  rsp_seller_ff <= buy_ff ? slot_id_ff[best_ff] : id_ff;
                  rsp_price_ff  <= slot_price_ff[best_ff];
                  rsp_fqty_ff   <= fill;
                  rsp_seq_ff    <= trade_ff;
                  rsp_status_ff <= ST_OK;
                  rsp_left_ff   <= '0;
                  rsp_last_ff   <= 1'b0;
                  trade_ff      <= trade_ff + 1'b1;
                  fills_ff      <= fills_ff + 1'b1;
                  qty_ff        <= qty_ff - fill;
                  slot_qty_ff[best_ff] <= slot_qty_ff[best_ff] - fill;
                  if (slot_qty_ff[best_ff] == fill) slot_valid_ff[best_ff] <= 1'b0;
                  found_ff   <= 1'b0;
                  free_ok_ff <= 1'b0;
               end else begin
                  // Final status; rest, cancel or modify.
                  rsp_valid_ff  <= 1'b1;
                  rsp_trade_ff  <= 1'b0;
                  rsp_buyer_ff  <= '0;
                  rsp_seller_ff <= '0;
                  rsp_price_ff  <= '0;
                  rsp_fqty_ff   <= '0;
                  rsp_seq_ff    <= '0;
                  rsp_last_ff   <= 1'b1;
                  if (kind_ff == KIND_ADD) begin
                     rsp_left_ff <= qty_ff;
                     if (qty_ff != '0 && !free_ok_ff) begin
                        rsp_status_ff <= ST_BOOK_FULL;
                     end else begin
                        rsp_status_ff <= ST_OK;
                        if (qty_ff != '0) begin
                           slot_valid_ff[free_ff] <= 1'b1;
                           slot_id_ff[free_ff]    <= id_ff;
                           slot_buy_ff[free_ff]   <= buy_ff;
                           slot_price_ff[free_ff] <= limit_ff;
                           slot_qty_ff[free_ff]   <= qty_ff;
                           slot_arr_ff[free_ff]   <= arrival_ff;
                           arrival_ff <= arrival_ff + 1'b1;
                        end
                     end
                  end else begin
                     rsp_left_ff <= '0;
                     if (!found_ff) begin
                        rsp_status_ff <= ST_NOT_FOUND;
                     end else begin
                        rsp_status_ff <= ST_OK;
                        if (kind_ff == KIND_CANCEL || qty_ff == '0)
                           slot_valid_ff[best_ff] <= 1'b0;
                        else
                           slot_qty_ff[best_ff] <= qty_ff;
                     end
                  end
               end
            end
            S_EMIT: ;
            S_DONE: if (rsp_free) begin
               rsp_valid_ff  <= 1'b1;
               rsp_trade_ff  <= 1'b0;
               rsp_buyer_ff  <= '0;
               rsp_seller_ff <= '0;
               rsp_price_ff  <= '0;
               rsp_fqty_ff   <= '0;
               rsp_seq_ff    <= '0;
               rsp_last_ff   <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   // The sequencer returns to idle after a final status.
   logic final_sent_ff;
   always_ff @(posedge clock) begin
      if (reset) final_sent_ff <= 1'b0;
      else final_sent_ff <= (state_ff == S_FILL) && rsp_free && !do_trade;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.is_trade      = rsp_trade_ff;
   assign rsp.buyer_id      = rsp_buyer_ff;
   assign rsp.seller_id     = rsp_seller_ff;
   assign rsp.fill_price    = rsp_price_ff;
   assign rsp.fill_quantity = rsp_fqty_ff;
   assign rsp.fill_sequence = rsp_seq_ff;
   assign rsp.status        = rsp_status_ff;
   assign rsp.left_over     = rsp_left_ff;
   assign rsp.last          = rsp_last_ff;

   // Checks.
   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req.ready) else $error("ready while busy");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fills_ff <= (FillCntWidth+1)'(MaxFills)) else $error("too many fills");
   a_trade_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_trade_ff |-> !rsp_last_ff) else $error("trade marked last");
   a_final_status: assert property (@(posedge clock) disable iff (reset)
      final_sent_ff |-> rsp_valid_ff && rsp_last_ff) else $error("status lost");
endmodule
`default_nettype wire

FILE: tb/sv/limit_order_book_matcher_tb.sv
// Self-checking testbench for the limit order book matcher: a directed
// opening, then random add/cancel/modify traffic under random handshake idling.
// Depends on lobm_pkg, lobm_if.sv and the limit_order_book_matcher top level.
`timescale 1ns / 1ps
module limit_order_book_matcher_tb;
   import lobm_pkg::*;

   localparam int Depth = 32;
   localparam int CycleLimit = 4000000;
   localparam int PendDepth = 1024;
   localparam int ExpDepth = 256;
   localparam logic [1:0] KindUnknown = 2'd3;

   typedef struct packed {
      logic [1:0]            kind;
      logic [IdWidth-1:0]    order_id;
      logic                  is_buy;
      logic [PriceWidth-1:0] limit_price;
      logic [QtyWidth-1:0]   quantity;
   } order_req_type;

   typedef struct packed {
      logic                  is_trade;
      logic [IdWidth-1:0]    buyer_id;
      logic [IdWidth-1:0]    seller_id;
      logic [PriceWidth-1:0] fill_price;
      logic [QtyWidth-1:0]   fill_quantity;
      logic [SeqWidth-1:0]   fill_sequence;
      logic [2:0]            status;
      logic [QtyWidth-1:0]   left_over;
      logic                  last;
   } book_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   lobm_req_if req_ch ();
   lobm_rsp_if rsp_ch ();

   limit_order_book_matcher #(.BOOK_DEPTH(Depth)) dut (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source)
   );

   always #6 clock = ~clock;

   // Shadow book kept by the predictor.
   logic                  bk_valid [Depth] = '{default: 1'b0};
   logic [IdWidth-1:0]    bk_id [Depth];
   logic                  bk_buy [Depth];
   logic [PriceWidth-1:0] bk_price [Depth];
   logic [QtyWidth-1:0]   bk_qty [Depth];
   logic [31:0]           bk_arrival [Depth];
   logic [31:0]           arrival_count = '0;
   logic [31:0]           trade_count = '0;

   // Pending requests and expected results, kept as arrays with read and write counts.
   order_req_type pend_mem [PendDepth];
   book_rsp_type  exp_mem [ExpDepth];
   int  pend_wr = 0;
   int  pend_rd = 0;
   int  exp_wr = 0;
   int  exp_rd = 0;
   int  mismatches = 0;
   int  cycles = 0;
   int  requests_sent = 0;
   int  results_seen = 0;
   int  trades_seen = 0;
   int  send_idle_pct = 10;
   int  take_idle_pct = 50;
   int  hold_off_cycles = 0;
   bit  want_hold = 0;
   bit  hold_done = 0;

   function automatic book_rsp_type status_rsp(logic [2:0] st, logic [QtyWidth-1:0] left);
      book_rsp_type r;
      r = '0;
      r.status = st;
      r.left_over = left;
      r.last = 1'b1;
      return r;
   endfunction

   function automatic void queue_result(book_rsp_type r);
      exp_mem[exp_wr % ExpDepth] = r;
      exp_wr++;
   endfunction

   function automatic void add_req(order_req_type r);
      pend_mem[pend_wr] = r;
      pend_wr++;
   endfunction

   // Best crossing order on the opposite side; -1 when nothing crosses.
   function automatic int best_counter_slot(logic buy, logic [PriceWidth-1:0] limit);
      int best;
      best = -1;
      for (int i = 0; i < Depth; i++) begin
         if (!bk_valid[i] || bk_buy[i] == buy) continue;
         if (buy ? (bk_price[i] > limit) : (bk_price[i] < limit)) continue;
         if (best < 0) begin
            best = i;
         end else if (buy ? (bk_price[i] < bk_price[best]) : (bk_price[i] > bk_price[best])) begin
            best = i;
         end else if (bk_price[i] == bk_price[best] &&
                      32'(arrival_count - bk_arrival[i]) >
                      32'(arrival_count - bk_arrival[best])) begin
            best = i;
         end
      end
      return best;
   endfunction

   // Apply one request to the shadow book and queue its expected results.
   task automatic predict_book(input order_req_type q);
      logic [QtyWidth-1:0] rem, f;
      logic [2:0] st;
      int s, n, fr;
      book_rsp_type t;
      n = 0;
      s = -1;
      fr = -1;
      if (q.kind == KIND_ADD) begin
         if (q.quantity == 0) begin
            queue_result(status_rsp(ST_BAD_QTY, 0));
         end else if (q.limit_price == 0) begin
            queue_result(status_rsp(ST_BAD_PRICE, 0));
         end else begin
            rem = q.quantity;
            while (rem > 0 && n < MaxFills) begin
               s = best_counter_slot(q.is_buy, q.limit_price);
               if (s < 0) break;
               f = (rem < bk_qty[s]) ? rem : bk_qty[s];
               t = '0;
               t.is_trade = 1'b1;
               t.buyer_id = q.is_buy ? q.order_id : bk_id[s];
               t.seller_id = q.is_buy ? bk_id[s] : q.order_id;
               t.fill_price = bk_price[s];
               t.fill_quantity = f;
               t.fill_sequence = trade_count;
               queue_result(t);
               n++;
               trade_count++;
               rem -= f;
               bk_qty[s] -= f;
               if (bk_qty[s] == 0) bk_valid[s] = 1'b0;
            end
            st = ST_OK;
            if (rem > 0) begin
               for (int i = Depth - 1; i >= 0; i--)
                  if (!bk_valid[i]) fr = i;
               if (fr < 0) begin
                  st = ST_BOOK_FULL;
               end else begin
                  bk_valid[fr] = 1'b1;
                  bk_id[fr] = q.order_id;
                  bk_buy[fr] = q.is_buy;
                  bk_price[fr] = q.limit_price;
                  bk_qty[fr] = rem;
                  bk_arrival[fr] = arrival_count;
                  arrival_count++;
               end
            end
            queue_result(status_rsp(st, rem));
         end
      end else if (q.kind == KIND_CANCEL || q.kind == KIND_MODIFY) begin
         for (int i = Depth - 1; i >= 0; i--)
            if (bk_valid[i] && bk_id[i] == q.order_id) s = i;
         if (s < 0) begin
            queue_result(status_rsp(ST_NOT_FOUND, 0));
         end else begin
            if (q.kind == KIND_CANCEL || q.quantity == 0) bk_valid[s] = 1'b0;
            else bk_qty[s] = q.quantity;
            queue_result(status_rsp(ST_OK, 0));
         end
      end else begin
         queue_result(status_rsp(ST_OK, 0));
      end
   endtask

   function automatic order_req_type make_req(logic [1:0] k, logic [31:0] id, logic b,
                                              logic [15:0] p, logic [23:0] qty);
      order_req_type r;
      r.kind = k;
      r.order_id = id;
      r.is_buy = b;
      r.limit_price = p;
      r.quantity = qty;
      return r;
   endfunction

   // Driver: offers the oldest pending request, with random idle cycles.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         {req_ch.kind, req_ch.order_id, req_ch.is_buy, req_ch.limit_price,
          req_ch.quantity} <= '0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predict_book(pend_mem[pend_rd]);
            pend_rd++;
            requests_sent++;
         end
         if ((!req_ch.valid || req_ch.ready) && pend_wr > pend_rd) begin
            if ($urandom_range(99) >= send_idle_pct) begin
               req_ch.valid <= 1'b1;
               {req_ch.kind, req_ch.order_id, req_ch.is_buy, req_ch.limit_price,
                req_ch.quantity} <= pend_mem[pend_rd];
            end else begin
               req_ch.valid <= 1'b0;
            end
         end else if (req_ch.valid && req_ch.ready) begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Receiver back-pressure: random idling, or one long hold-off when asked.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_ch.ready <= 1'b0;
      end else if (want_hold && !hold_done) begin
         hold_off_cycles <= 400;
         hold_done <= 1'b1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= take_idle_pct);
      end
   end

   // Monitor: compare each accepted result with the oldest expectation.
   always @(posedge clock) begin
      book_rsp_type got, exp_r;
      cycles <= cycles + 1;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = {rsp_ch.is_trade, rsp_ch.buyer_id, rsp_ch.seller_id, rsp_ch.fill_price,
                rsp_ch.fill_quantity, rsp_ch.fill_sequence, rsp_ch.status,
                rsp_ch.left_over, rsp_ch.last};
         results_seen++;
         if (got.is_trade) trades_seen++;
         if (exp_wr == exp_rd) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
         end else begin
            exp_r = exp_mem[exp_rd % ExpDepth];
            exp_rd++;
            if (got !== exp_r) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: trade %b/%b buyer %h/%h seller %h/%h price %h/%h",
                           exp_r.is_trade, got.is_trade, exp_r.buyer_id, got.buyer_id,
                           exp_r.seller_id, got.seller_id, exp_r.fill_price,
                           got.fill_price);
                  $display("  qty %h/%h seq %h/%h status %h/%h left %h/%h last %b/%b",
                           exp_r.fill_quantity, got.fill_quantity, exp_r.fill_sequence,
                           got.fill_sequence, exp_r.status, got.status, exp_r.left_over,
                           got.left_over, exp_r.last, got.last);
               end
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("limit_order_book_matcher_tb: errors");
         $finish;
      end
   end

   // Random order over a small id and price range, so cancels hit and books cross.
   function automatic order_req_type random_req();
      int pick;
      logic [23:0] qty;
      logic [15:0] p;
      logic [31:0] id;
      logic b;
      pick = $urandom_range(99);
      qty = ($urandom_range(19) == 0) ? 24'($urandom) : 24'($urandom_range(1, 60));
      p = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(95, 105));
      id = 32'($urandom_range(1, 40));
      b = 1'($urandom_range(1));
      if (pick < 3) qty = 0;
      else if (pick < 6) p = 0;
      if (pick < 60)
         return make_req(KIND_ADD, id, b, p, qty);
      else if (pick < 78)
         return make_req(KIND_CANCEL, id, b, p, qty);
      else if (pick < 96)
         return make_req(KIND_MODIFY, id, b, p,
                         ($urandom_range(4) == 0) ? 24'd0 : qty);
      else if (pick < 98)
         return make_req(KindUnknown, 32'($urandom), b, p, qty);
      return make_req(KIND_ADD, 32'($urandom), b, 16'($urandom), 24'($urandom));
   endfunction

   task automatic wait_drained();
      while (pend_wr > pend_rd || req_ch.valid || exp_wr > exp_rd)
         @(posedge clock);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed opening: rejects, field extremes, crossing, cancel, modify.
      add_req(make_req(KIND_ADD, 32'd1, 1'b1, 16'd100, 24'd0));
      add_req(make_req(KIND_ADD, 32'd1, 1'b1, 16'd0, 24'd5));
      add_req(make_req(KIND_ADD, 32'hFFFF_FFFF, 1'b0, 16'hFFFF, 24'hFF_FFFF));
      add_req(make_req(KIND_ADD, 32'd0, 1'b0, 16'd1, 24'd1));
      add_req(make_req(KIND_ADD, 32'd10, 1'b0, 16'd101, 24'd10));
      add_req(make_req(KIND_ADD, 32'd11, 1'b0, 16'd101, 24'd10));
      add_req(make_req(KIND_ADD, 32'd12, 1'b1, 16'hFFFF, 24'd25));
      add_req(make_req(KIND_CANCEL, 32'd12, 1'b0, 16'd0, 24'd0));
      add_req(make_req(KIND_CANCEL, 32'd999, 1'b0, 16'd0, 24'd0));
      add_req(make_req(KIND_MODIFY, 32'hFFFF_FFFF, 1'b0, 16'd0, 24'd7));
      add_req(make_req(KIND_MODIFY, 32'hFFFF_FFFF, 1'b0, 16'd0, 24'd0));
      add_req(make_req(KIND_MODIFY, 32'd77, 1'b0, 16'd0, 24'd3));
      add_req(make_req(KindUnknown, 32'h5555_AAAA, 1'b1, 16'hAAAA, 24'h55_AAAA));
      // Fill the book with 32 one-lot sells, overflow it, then sweep it.
      for (int i = 0; i < Depth + 1; i++)
         add_req(make_req(KIND_ADD, 32'(200 + i), 1'b0, 16'(50 + i % 3), 24'd1));
      add_req(make_req(KIND_ADD, 32'd300, 1'b1, 16'd60, 24'd40));
      add_req(make_req(KIND_CANCEL, 32'd300, 1'b0, 16'd0, 24'd0));
      wait_drained();

      // Random phases, each with its own idling mix.
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 10 : (ph == 1) ? 50 : 0;
         take_idle_pct = (ph == 0) ? 50 : (ph == 1) ? 10 : 0;
         for (int i = 0; i < 110; i++) add_req(random_req());
         if (ph == 2) want_hold = 1'b1;
         wait_drained();
         // Thin out the book between phases so later phases see empty and full states.
         if (ph < 2) begin
            for (int id = 1; id <= 40; id++)
               add_req(make_req(KIND_CANCEL, 32'(id), 1'b0, 16'd0, 24'd0));
            wait_drained();
         end
      end
      repeat (100) @(posedge clock);

      $display("covered %0d requests, %0d results, %0d of them trades", requests_sent,
               results_seen, trades_seen);
      if (mismatches == 0 && exp_wr == exp_rd)
         $display("limit_order_book_matcher_tb: clean");
      else
         $display("limit_order_book_matcher_tb: errors");
      $finish;
   end
endmodule
